// ----- design/dbpsk_pkg.sv -----
// Types, tables and helpers shared by the DBPSK pulse-shaping modulator.
`default_nettype none

package dbpsk_pkg;

  // Symbol codes held in the history line
  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  localparam int PULSE_HALF = 16;
  localparam int HIST_DEPTH = 4;

  localparam int SUM_W  = 18;
  localparam int COS_W  = 16;
  localparam int PROD_W = SUM_W + COS_W;

  localparam logic [7:0] CARRIER_STEP_RESET = 8'd32;

  // Register byte addresses (index in bits above the word offset)
  localparam logic [0:0] REG_CARRIER_STEP = 1'b0;

  typedef logic [1:0] sym_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [COS_W-1:0] cos_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Q1.15 pulse shape, 33 points over two symbol periods
  function automatic logic signed [15:0] pulse_val(input logic [5:0] idx);
    logic signed [15:0] v;
    case (idx)
      6'd0:  v = 16'sd32767;
      6'd1:  v = 16'sd32528;
      6'd2:  v = 16'sd31816;
      6'd3:  v = 16'sd30652;
      6'd4:  v = 16'sd29073;
      6'd5:  v = 16'sd27124;
      6'd6:  v = 16'sd24863;
      6'd7:  v = 16'sd22354;
      6'd8:  v = 16'sd19668;
      6'd9:  v = 16'sd16878;
      6'd10: v = 16'sd14057;
      6'd11: v = 16'sd11276;
      6'd12: v = 16'sd8602;
      6'd13: v = 16'sd6092;
      6'd14: v = 16'sd3797;
      6'd15: v = 16'sd1757;
      6'd16: v = 16'sd0;
      6'd17: v = -16'sd1456;
      6'd18: v = -16'sd2606;
      6'd19: v = -16'sd3454;
      6'd20: v = -16'sd4014;
      6'd21: v = -16'sd4310;
      6'd22: v = -16'sd4372;
      6'd23: v = -16'sd4234;
      6'd24: v = -16'sd3934;
      6'd25: v = -16'sd3511;
      6'd26: v = -16'sd3005;
      6'd27: v = -16'sd2453;
      6'd28: v = -16'sd1888;
      6'd29: v = -16'sd1339;
      6'd30: v = -16'sd830;
      6'd31: v = -16'sd380;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Q1.15 quarter-wave cosine, 65 points
  function automatic logic [14:0] quarter_cos(input logic [6:0] r);
    logic [14:0] v;
    case (r)
      7'd0:  v = 15'd32767; 7'd1:  v = 15'd32758; 7'd2:  v = 15'd32729;
      7'd3:  v = 15'd32679; 7'd4:  v = 15'd32610; 7'd5:  v = 15'd32522;
      7'd6:  v = 15'd32413; 7'd7:  v = 15'd32286; 7'd8:  v = 15'd32138;
      7'd9:  v = 15'd31972; 7'd10: v = 15'd31786; 7'd11: v = 15'd31581;
      7'd12: v = 15'd31357; 7'd13: v = 15'd31114; 7'd14: v = 15'd30853;
      7'd15: v = 15'd30572; 7'd16: v = 15'd30274; 7'd17: v = 15'd29957;
      7'd18: v = 15'd29622; 7'd19: v = 15'd29269; 7'd20: v = 15'd28899;
      7'd21: v = 15'd28511; 7'd22: v = 15'd28106; 7'd23: v = 15'd27684;
      7'd24: v = 15'd27246; 7'd25: v = 15'd26791; 7'd26: v = 15'd26320;
      7'd27: v = 15'd25833; 7'd28: v = 15'd25330; 7'd29: v = 15'd24812;
      7'd30: v = 15'd24279; 7'd31: v = 15'd23732; 7'd32: v = 15'd23170;
      7'd33: v = 15'd22595; 7'd34: v = 15'd22006; 7'd35: v = 15'd21403;
      7'd36: v = 15'd20788; 7'd37: v = 15'd20160; 7'd38: v = 15'd19520;
      7'd39: v = 15'd18868; 7'd40: v = 15'd18205; 7'd41: v = 15'd17531;
      7'd42: v = 15'd16846; 7'd43: v = 15'd16151; 7'd44: v = 15'd15447;
      7'd45: v = 15'd14733; 7'd46: v = 15'd14010; 7'd47: v = 15'd13279;
      7'd48: v = 15'd12540; 7'd49: v = 15'd11793; 7'd50: v = 15'd11039;
      7'd51: v = 15'd10279; 7'd52: v = 15'd9512;  7'd53: v = 15'd8740;
      7'd54: v = 15'd7962;  7'd55: v = 15'd7180;  7'd56: v = 15'd6393;
      7'd57: v = 15'd5602;  7'd58: v = 15'd4808;  7'd59: v = 15'd4011;
      7'd60: v = 15'd3212;  7'd61: v = 15'd2411;  7'd62: v = 15'd1608;
      7'd63: v = 15'd804;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Full-wave cosine by quadrant folding
  function automatic cos_t cos_lookup(input logic [7:0] p);
    logic [6:0]  r;
    logic [6:0]  rm;
    logic [14:0] mag;
    cos_t        v;
    r  = {1'b0, p[5:0]};
    rm = 7'd64 - r;
    case (p[7:6])
      2'd0: begin
        mag = quarter_cos(r);
        v   = cos_t'({1'b0, mag});
      end
      2'd1: begin
        mag = quarter_cos(rm);
        v   = -cos_t'({1'b0, mag});
      end
      2'd2: begin
        mag = quarter_cos(r);
        v   = -cos_t'({1'b0, mag});
      end
      default: begin
        mag = quarter_cos(rm);
        v   = cos_t'({1'b0, mag});
      end
    endcase
    return v;
  endfunction

  // Apply a symbol of -1, 0 or +1 to a pulse value
  function automatic sum_t weigh(input sym_t s, input logic signed [15:0] v);
    sum_t w;
    w = sum_t'(v);
    case (s)
      SYM_POS: return w;
      SYM_NEG: return -w;
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- design/dbpsk_pulse_shaping_modulator_core.sv -----
// An accepted bit enters the history line; its samples pass the sum/cosine, product
// and sample registers to out_valid. Throughput: one sample per cycle unless stalled;
// each bit gives SAMPLES_PER_SYMBOL samples; a new bit is taken in the last slot.
// The pipeline is sum/cosine, multiply, round/saturate; out_ready low stalls it.
// Reset (rst, synchronous): level +1, history all zero, phase zero, step 32.
`default_nettype none

module dbpsk_pulse_shaping_modulator_core #(
  parameter int SAMPLES_PER_SYMBOL = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        data_bit,
  input  wire logic        silent,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] sample,
  output logic             last
);
  import dbpsk_pkg::*;

  localparam int KW    = (SAMPLES_PER_SYMBOL > 1) ? $clog2(SAMPLES_PER_SYMBOL) : 1;
  localparam int RW    = $clog2(2 * SAMPLES_PER_SYMBOL) + 1;
  localparam int QSTEP = PULSE_HALF / SAMPLES_PER_SYMBOL;
  localparam int RSTEP = PULSE_HALF % SAMPLES_PER_SYMBOL;
  localparam logic [KW-1:0] K_LAST = KW'(SAMPLES_PER_SYMBOL - 1);
  localparam logic [RW-1:0] R_STEP = RW'(RSTEP);
  localparam logic [RW-1:0] R_MOD  = RW'(SAMPLES_PER_SYMBOL);
  localparam logic [3:0]    J_STEP = 4'(QSTEP);

  // Configuration
  logic [7:0] carrier_step;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_step <= CARRIER_STEP_RESET;
    end else if (cfg_wr && paddr[2] == REG_CARRIER_STEP) begin
      carrier_step <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CARRIER_STEP) begin
      prdata = {24'd0, carrier_step};
    end
  end

  // Slot generator
  logic          adv;
  logic          busy;
  logic [KW-1:0] k;
  logic [3:0]    j;
  logic [RW-1:0] r;
  logic [7:0]    carrier_phase;
  logic          diff_level;
  sym_t          hist [HIST_DEPTH];
  logic          in_fire;
  logic          k_end;
  logic          lvl_next;
  sym_t          sym_next;
  logic [RW-1:0] r_sum;
  logic          r_wrap;

  assign adv      = !out_valid || out_ready;
  assign k_end    = (k == K_LAST);
  assign in_ready = !busy || (k_end && adv);
  assign in_fire  = in_valid && in_ready;
  assign lvl_next = diff_level ^ data_bit;
  assign sym_next = silent ? SYM_ZERO : (lvl_next ? SYM_NEG : SYM_POS);
  assign r_sum    = r + R_STEP;
  assign r_wrap   = (r_sum >= R_MOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      k             <= '0;
      j             <= '0;
      r             <= '0;
      carrier_phase <= '0;
      diff_level    <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= SYM_ZERO;
      end
    end else begin
      if (in_fire) begin
        if (!silent) begin
          diff_level <= lvl_next;
        end
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
          hist[i] <= hist[i+1];
        end
        hist[HIST_DEPTH-1] <= sym_next;
      end
      if (busy && adv) begin
        carrier_phase <= carrier_phase + carrier_step;
        if (k_end) begin
          k    <= '0;
          j    <= '0;
          r    <= '0;
          busy <= in_fire;
        end else begin
          k <= k + 1'b1;
          // step pulse position by SAMPLES_PER_SYMBOL-th of the half table
          if (r_wrap) begin
            j <= j + J_STEP + 4'd1;
            r <= r_sum - R_MOD;
          end else begin
            j <= j + J_STEP;
            r <= r_sum;
          end
        end
      end else if (in_fire) begin
        busy <= 1'b1;
      end
    end
  end

  // Shaping sum and carrier for the current slot
  sum_t       sum0;
  cos_t       cos0;
  logic [5:0] jx;

  assign jx = {2'b00, j};

  always_comb begin
    sum0 = weigh(hist[0], pulse_val(6'd16 + jx))
         + weigh(hist[1], pulse_val(jx))
         + weigh(hist[2], pulse_val(6'd16 - jx))
         + weigh(hist[3], pulse_val(6'd32 - jx));
    cos0 = cos_lookup(carrier_phase);
  end

  // Pipeline: sum/cos, product, output
  logic  v1;
  logic  last1;
  sum_t  sum1;
  cos_t  cos1;
  logic  v2;
  logic  last2;
  prod_t prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= busy;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  prod_t                 rnd;
  logic signed [SUM_W-1:0] shifted;
  logic signed [15:0]    sat;

  always_comb begin
    rnd     = prod2 + prod_t'(32768);
    shifted = rnd[PROD_W-1:16];
    if (shifted > SUM_W'(32767)) begin
      sat = 16'sd32767;
    end else if (shifted < -SUM_W'(32768)) begin
      sat = -16'sd32768;
    end else begin
      sat = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum1   <= sum0;
      cos1   <= cos0;
      last1  <= k_end;
      prod2  <= prod_t'(sum1) * prod_t'(cos1);
      last2  <= last1;
      sample <= sat;
      last   <= last2;
    end
  end

endmodule

`default_nettype wire

// ----- sim/dbpsk_pulse_shaping_modulator_core_test.sv -----
// Self-checking testbench for the DBPSK pulse-shaping modulator core.
`default_nettype none

module dbpsk_pulse_shaping_modulator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dbpsk_pkg::*;

  localparam int SPS         = 16;
  localparam int HALF        = 16;
  localparam int N_DIRECTED  = 20;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 30;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_PRINTS  = 40;

  // Index with no register behind it
  localparam logic [0:0] REG_SPARE = 1'b1;

  typedef struct packed {
    logic signed [15:0] level;
    logic               last;
  } out_beat_t;

  // One directed symbol; fixed rows carry the value every sample must take
  typedef struct packed {
    logic               dbit;
    logic               quiet;
    logic               fixed;
    logic signed [15:0] flat;
  } sym_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        data_bit = 1'b0;
  logic        silent = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] sample;
  logic        last;

  int pulse_shape [0:32] = '{
    32767, 32528, 31816, 30652, 29073, 27124, 24863, 22354,
    19668, 16878, 14057, 11276, 8602, 6092, 3797, 1757,
    0, -1456, -2606, -3454, -4014, -4310, -4372, -4234,
    -3934, -3511, -3005, -2453, -1888, -1339, -830, -380,
    0
  };

  int cos_quarter [0:64] = '{
    32767, 32758, 32729, 32679, 32610, 32522, 32413, 32286,
    32138, 31972, 31786, 31581, 31357, 31114, 30853, 30572,
    30274, 29957, 29622, 29269, 28899, 28511, 28106, 27684,
    27246, 26791, 26320, 25833, 25330, 24812, 24279, 23732,
    23170, 22595, 22006, 21403, 20788, 20160, 19520, 18868,
    18205, 17531, 16846, 16151, 15447, 14733, 14010, 13279,
    12540, 11793, 11039, 10279, 9512, 8740, 7962, 7180,
    6393, 5602, 4808, 4011, 3212, 2411, 1608, 804,
    0
  };

  sym_row_t directed_syms [0:N_DIRECTED-1] = '{
    '{1'b0, 1'b1, 1'b1, 16'sd0},  // silent right after reset
    '{1'b1, 1'b1, 1'b1, 16'sd0},  // both set: silent wins, no flip
    '{1'b0, 1'b0, 1'b0, 16'sd0},
    '{1'b1, 1'b0, 1'b0, 16'sd0},
    '{1'b1, 1'b0, 1'b0, 16'sd0},
    '{1'b0, 1'b0, 1'b0, 16'sd0},
    '{1'b1, 1'b1, 1'b0, 16'sd0},
    '{1'b0, 1'b0, 1'b0, 16'sd0},
    '{1'b0, 1'b1, 1'b0, 16'sd0},
    '{1'b0, 1'b1, 1'b0, 16'sd0},
    '{1'b0, 1'b1, 1'b0, 16'sd0},
    '{1'b1, 1'b1, 1'b1, 16'sd0},  // history fully flushed with zero symbols
    '{1'b1, 1'b0, 1'b0, 16'sd0},
    '{1'b1, 1'b0, 1'b0, 16'sd0},
    '{1'b1, 1'b0, 1'b0, 16'sd0},
    '{1'b1, 1'b0, 1'b0, 16'sd0},
    '{1'b0, 1'b0, 1'b0, 16'sd0},
    '{1'b0, 1'b0, 1'b0, 16'sd0},
    '{1'b0, 1'b0, 1'b0, 16'sd0},
    '{1'b1, 1'b0, 1'b0, 16'sd0}
  };

  // Modulator state as predicted
  logic       level_neg = 1'b0;
  sym_t       sym_line [0:3] = '{SYM_ZERO, SYM_ZERO, SYM_ZERO, SYM_ZERO};
  logic [7:0] phase_acc = 8'd0;
  logic [7:0] step_reg = CARRIER_STEP_RESET;

  out_beat_t samples_due [$];
  int        errors = 0;
  bit        tx_gaps = 1'b1;
  bit        rx_gaps = 1'b1;
  int        rx_hold_cycles = 0;

  dbpsk_pulse_shaping_modulator_core #(
    .SAMPLES_PER_SYMBOL(SPS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .data_bit (data_bit),
    .silent   (silent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample   (sample),
    .last     (last)
  );

  always #10 clk = ~clk;

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  function automatic int carrier_cos(input logic [7:0] p);
    int r;
    r = p[5:0];
    case (p[7:6])
      2'd0:    return cos_quarter[r];
      2'd1:    return -cos_quarter[64 - r];
      2'd2:    return -cos_quarter[r];
      default: return cos_quarter[64 - r];
    endcase
  endfunction

  function automatic int tap(input sym_t s, input int v);
    case (s)
      SYM_POS: return v;
      SYM_NEG: return -v;
      default: return 0;
    endcase
  endfunction

  // Advance the predicted state by one symbol and queue its samples
  task automatic shape_symbol(input logic dbit, input logic quiet, input logic fixed,
                              input logic signed [15:0] flat);
    sym_t      sy;
    int        j;
    int        acc;
    longint    prod;
    longint    v;
    out_beat_t e;
    if (quiet) begin
      sy = SYM_ZERO;
    end else begin
      if (dbit) level_neg = ~level_neg;
      sy = level_neg ? SYM_NEG : SYM_POS;
    end
    sym_line[0] = sym_line[1];
    sym_line[1] = sym_line[2];
    sym_line[2] = sym_line[3];
    sym_line[3] = sy;
    for (int k = 0; k < SPS; k++) begin
      j = (k * HALF) / SPS;
      if (j > HALF - 1) j = HALF - 1;
      acc = tap(sym_line[0], pulse_shape[HALF + j]) + tap(sym_line[1], pulse_shape[j])
          + tap(sym_line[2], pulse_shape[HALF - j]) + tap(sym_line[3], pulse_shape[2*HALF - j]);
      prod = longint'(acc) * longint'(carrier_cos(phase_acc));
      phase_acc = phase_acc + step_reg;
      // round half up, then clamp to Q2.14 range
      v = (prod + 64'sd32768) >>> 16;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      e.level = fixed ? flat : 16'(v);
      e.last  = (k == SPS - 1);
      samples_due.push_back(e);
    end
  endtask

  task automatic send_symbol(input logic dbit, input logic quiet, input logic fixed,
                             input logic signed [15:0] flat);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_bit <= dbit;
    silent   <= quiet;
    do @(posedge clk); while (!in_ready);
    shape_symbol(dbit, quiet, fixed, flat);
  endtask

  task automatic apb_write(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_CARRIER_STEP) step_reg = val[7:0];
  endtask

  task automatic check_step_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_CARRIER_STEP, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(step_reg)) begin
      note_error($sformatf("carrier_step read %0d, want %0d", prdata, step_reg));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold off until every queued sample has come, then let the pipeline settle
  task automatic drain();
    while (samples_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [7:0] phase_steps [0:4];
    logic [7:0] st;
    logic       quiet;
    phase_steps = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd64};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    check_step_readback();
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_symbol(directed_syms[i].dbit, directed_syms[i].quiet,
                  directed_syms[i].fixed, directed_syms[i].flat);
    end
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      st = (ph < 5) ? phase_steps[ph] : 8'($urandom_range(0, 255));
      apb_write(REG_CARRIER_STEP, {24'($urandom), st});
      check_step_readback();
      if (ph == 2) begin
        // write to a hole in the map; step must stay as it was
        apb_write(REG_SPARE, $urandom);
        check_step_readback();
      end
      tx_gaps = (ph != 2 && ph != 4 && ph != 5);
      rx_gaps = (ph != 3 && ph != 4);
      // stall the output long enough to back the input up
      if (ph == 5) rx_hold_cycles = LONG_HOLD;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        quiet = ($urandom_range(0, 3) == 0);
        send_symbol(1'($urandom_range(0, 1)), quiet, 1'b0, 16'sd0);
      end
      in_valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("dbpsk_pulse_shaping_modulator_core_test: clean");
    end else begin
      $display("dbpsk_pulse_shaping_modulator_core_test: errors");
    end
    $finish;
  end

  // Output side: random stalls, optional long hold, check every beat
  initial begin
    int        stall;
    out_beat_t e;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_gaps ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (samples_due.size() == 0) begin
        note_error($sformatf("sample %0d with nothing pending", sample));
      end else begin
        e = samples_due.pop_front();
        if (sample !== e.level) begin
          note_error($sformatf("sample %0d, want %0d", sample, e.level));
        end
        if (last !== e.last) begin
          note_error($sformatf("last %0b, want %0b", last, e.last));
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("dbpsk_pulse_shaping_modulator_core_test: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/dbpsk_pkg.sv
design/dbpsk_pulse_shaping_modulator_core.sv
sim/dbpsk_pulse_shaping_modulator_core_test.sv
